@@ rtl/core/pdvm_pkg.sv @@
// ----------------------------------------------------------------------------
// pdvm_pkg
// Shared types and constants of the perspective divide / viewport map block.
// ----------------------------------------------------------------------------
package pdvm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QW            = 32;   // width of every coordinate
    localparam int CFG_W         = 13;   // width of the size registers
    localparam int NUM_W         = 47;   // signed numerator width
    localparam int LANES         = 3;
    localparam int LANE_X        = 0;
    localparam int LANE_Y        = 1;
    localparam int LANE_Z        = 2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd800;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd600;

    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_SCREEN_WIDTH  = 1'b0;
    localparam t_reg_idx REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [QW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] SAT_MIN = 32'h8000_0000;

    // per-lane status carried down the divider chain
    typedef struct packed {
        logic neg;   // result is negative
        logic big;   // quotient magnitude >= 2^32
        logic dz;    // divisor is zero
        logic nz;    // numerator is nonzero
    } t_flags;

endpackage

@@ rtl/core/pdvm_in_if.sv @@
// ----------------------------------------------------------------------------
// pdvm_in_if
// Vertex input channel: valid/ready with clip-space payload.
// ----------------------------------------------------------------------------
interface pdvm_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;

    modport source (output valid, clip_x, clip_y, clip_z, clip_w, input ready);
    modport sink   (input valid, clip_x, clip_y, clip_z, clip_w, output ready);
endinterface

@@ rtl/core/pdvm_out_if.sv @@
// ----------------------------------------------------------------------------
// pdvm_out_if
// Screen position output channel: valid/ready with mapped payload.
// ----------------------------------------------------------------------------
interface pdvm_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
    logic              fault;

    modport source (output valid, screen_x, screen_y, depth, fault, input ready);
    modport sink   (input valid, screen_x, screen_y, depth, fault, output ready);
endinterface

@@ rtl/core/perspective_divide_viewport_map.sv @@
// ----------------------------------------------------------------------------
// perspective_divide_viewport_map
// Clip-space vertex to screen position: divide by w, then viewport map.
// ----------------------------------------------------------------------------
// One vertex is accepted per clock and one result leaves per clock while the
// output is not stalled. A vertex passes one numerator stage, 32 divider
// cells and one saturation/output stage, the first of these loaded on the
// accepting edge. The divider is a chain of identical
// restoring cells, one per quotient bit, each working x, y and z lanes of
// its vertex in parallel, so throughput is set by that chain being fully
// pipelined. Each stage holds its transaction while the next one is full
// and holding, so a stalled output only backs up as far as needed and
// bubbles collapse. Results are exact quotients rounded toward zero in
// Q(32-F).F, saturated to 32 signed bits; fault is set on zero w or any
// saturation. Size registers: index REG_SCREEN_WIDTH / REG_SCREEN_HEIGHT,
// write only while no vertex is in flight.
// ----------------------------------------------------------------------------
module perspective_divide_viewport_map
    import pdvm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_reg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    pdvm_in_if.sink          i_vtx,
    pdvm_out_if.source       o_pix
);

    localparam int RW   = 64 + FRAC_BITS;  // remainder width
    localparam int NSTG = QW + 1;          // prep stage + one per quotient bit

    // size registers
    logic [CFG_W-1:0] r_sw, r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= WIDTH_RST;
            r_sh <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCREEN_WIDTH:  r_sw <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_sh <= i_cfg_data;
                default:           r_sw <= r_sw;
            endcase
        end
    end

    // stage buses: index 0 is the prep register, s is after cell for bit QW-s
    logic          w_vld [NSTG];
    logic [RW-1:0] w_rem [NSTG][LANES];
    logic [QW-1:0] w_quo [NSTG][LANES];
    t_flags        w_flg [NSTG][LANES];
    logic [QW-1:0] w_den [NSTG];

    // load enables: a stage loads when empty or when its successor loads
    logic          w_ld [NSTG+1];
    logic          w_ld_out;
    logic [QW-1:0] w_res [LANES];
    logic          w_out_vld;
    logic          w_fault;

    assign w_ld_out   = !w_out_vld || o_pix.ready;

    always_comb begin
        w_ld[NSTG] = w_ld_out;
        for (int s = NSTG - 1; s >= 0; s--) begin
            w_ld[s] = !w_vld[s] || w_ld[s+1];
        end
    end

    assign i_vtx.ready = w_ld[0];

    pdvm_prep #(
        .FRAC_BITS (FRAC_BITS),
        .RW        (RW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_ld[0]),
        .i_vld   (i_vtx.valid),
        .i_x     (i_vtx.clip_x),
        .i_y     (i_vtx.clip_y),
        .i_z     (i_vtx.clip_z),
        .i_w     (i_vtx.clip_w),
        .i_sw    (r_sw),
        .i_sh    (r_sh),
        .o_vld   (w_vld[0]),
        .o_rem   (w_rem[0]),
        .o_quo   (w_quo[0]),
        .o_flg   (w_flg[0]),
        .o_den   (w_den[0])
    );

    for (genvar s = 1; s < NSTG; s++) begin : g_cell
        pdvm_cell #(
            .RW (RW),
            .K  (QW - s)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ld    (w_ld[s]),
            .i_vld   (w_vld[s-1]),
            .i_rem   (w_rem[s-1]),
            .i_quo   (w_quo[s-1]),
            .i_flg   (w_flg[s-1]),
            .i_den   (w_den[s-1]),
            .o_vld   (w_vld[s]),
            .o_rem   (w_rem[s]),
            .o_quo   (w_quo[s]),
            .o_flg   (w_flg[s]),
            .o_den   (w_den[s])
        );
    end

    pdvm_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_ld_out),
        .i_vld   (w_vld[NSTG-1]),
        .i_quo   (w_quo[NSTG-1]),
        .i_flg   (w_flg[NSTG-1]),
        .o_vld   (w_out_vld),
        .o_res   (w_res),
        .o_fault (w_fault)
    );

    assign o_pix.valid    = w_out_vld;
    assign o_pix.screen_x = $signed(w_res[LANE_X]);
    assign o_pix.screen_y = $signed(w_res[LANE_Y]);
    assign o_pix.depth    = $signed(w_res[LANE_Z]);
    assign o_pix.fault    = w_fault;

    // input side only backs off when the output transaction is stalled
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_vtx.ready |-> (o_pix.valid && !o_pix.ready))
        else $error("input stalled without output backpressure");

    // an accepted vertex lands in the prep register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vtx.valid && i_vtx.ready) |=> w_vld[0])
        else $error("accepted vertex lost at prep stage");

    // the last cell hands its vertex to the output register when it loads
    a_chain_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[NSTG-1] && w_ld_out) |=> o_pix.valid)
        else $error("vertex lost between divider and output");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_pix.valid)
        else $error("output valid right after reset");

endmodule

@@ rtl/core/pdvm_prep.sv @@
// ----------------------------------------------------------------------------
// pdvm_prep
// Forms numerators, magnitudes, signs and the quotient range check.
// ----------------------------------------------------------------------------
module pdvm_prep
    import pdvm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int RW        = 64 + FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ld,
    input  logic                i_vld,
    input  logic signed [QW-1:0] i_x,
    input  logic signed [QW-1:0] i_y,
    input  logic signed [QW-1:0] i_z,
    input  logic signed [QW-1:0] i_w,
    input  logic [CFG_W-1:0]    i_sw,
    input  logic [CFG_W-1:0]    i_sh,
    output logic                o_vld,
    output logic [RW-1:0]       o_rem [LANES],
    output logic [QW-1:0]       o_quo [LANES],
    output t_flags              o_flg [LANES],
    output logic [QW-1:0]       o_den
);

    logic                    r_vld;
    logic [RW-1:0]           r_rem [LANES];
    t_flags                  r_flg [LANES];
    logic [QW-1:0]           r_den;

    logic signed [QW:0]      n_sx, n_sy;
    logic signed [NUM_W-1:0] n_num [LANES];
    logic [QW-1:0]           n_den;
    logic [RW-1:0]           n_rem [LANES];
    t_flags                  n_flg [LANES];
    logic [RW-1:0]           n_lim;
    logic [NUM_W-1:0]        n_mag;

    always_comb begin
        n_sx = $signed({i_x[QW-1], i_x}) + $signed({i_w[QW-1], i_w});
        n_sy = $signed({i_w[QW-1], i_w}) - $signed({i_y[QW-1], i_y});
        n_num[LANE_X] = NUM_W'(n_sx) * NUM_W'($signed({1'b0, i_sw}));
        n_num[LANE_Y] = NUM_W'(n_sy) * NUM_W'($signed({1'b0, i_sh}));
        n_num[LANE_Z] = NUM_W'(i_z);
        n_den = i_w[QW-1] ? QW'(-i_w) : QW'(i_w);
        n_lim = RW'({n_den, {QW{1'b0}}});
        n_mag = '0;
        for (int l = 0; l < LANES; l++) begin
            n_mag = n_num[l][NUM_W-1] ? NUM_W'(-n_num[l]) : NUM_W'(n_num[l]);
            // depth keeps full fraction, x/y carry the /2 in the shift
            if (l == LANE_Z) begin
                n_rem[l] = RW'(n_mag) << FRAC_BITS;
            end else begin
                n_rem[l] = RW'(n_mag) << (FRAC_BITS - 1);
            end
            n_flg[l].dz  = (i_w == '0);
            n_flg[l].nz  = (n_num[l] != '0);
            n_flg[l].neg = n_flg[l].dz ? n_num[l][NUM_W-1]
                                       : (n_num[l][NUM_W-1] ^ i_w[QW-1]);
            n_flg[l].big = (n_rem[l] >= n_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ld) begin
            r_vld <= i_vld;
        end
        if (i_ld) begin
            r_rem <= n_rem;
            r_flg <= n_flg;
            r_den <= n_den;
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_flg = r_flg;
    assign o_den = r_den;
    always_comb begin
        for (int l = 0; l < LANES; l++) o_quo[l] = '0;
    end

endmodule

@@ rtl/core/pdvm_cell.sv @@
// ----------------------------------------------------------------------------
// pdvm_cell
// One restoring-division cell: settles quotient bit K on all three lanes.
// ----------------------------------------------------------------------------
module pdvm_cell
    import pdvm_pkg::*;
#(
    parameter int RW = 80,
    parameter int K  = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ld,
    input  logic          i_vld,
    input  logic [RW-1:0] i_rem [LANES],
    input  logic [QW-1:0] i_quo [LANES],
    input  t_flags        i_flg [LANES],
    input  logic [QW-1:0] i_den,
    output logic          o_vld,
    output logic [RW-1:0] o_rem [LANES],
    output logic [QW-1:0] o_quo [LANES],
    output t_flags        o_flg [LANES],
    output logic [QW-1:0] o_den
);

    logic          r_vld;
    logic [RW-1:0] r_rem [LANES];
    logic [QW-1:0] r_quo [LANES];
    t_flags        r_flg [LANES];
    logic [QW-1:0] r_den;

    logic [RW-1:0] n_dk;
    logic [RW-1:0] n_rem [LANES];
    logic [QW-1:0] n_quo [LANES];

    always_comb begin
        n_dk = RW'(i_den) << K;
        for (int l = 0; l < LANES; l++) begin
            n_rem[l] = i_rem[l];
            n_quo[l] = i_quo[l];
            if (i_rem[l] >= n_dk) begin
                n_rem[l]    = i_rem[l] - n_dk;
                n_quo[l][K] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ld) begin
            r_vld <= i_vld;
        end
        if (i_ld) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_flg <= i_flg;
            r_den <= i_den;
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_flg = r_flg;
    assign o_den = r_den;

endmodule

@@ rtl/core/pdvm_post.sv @@
// ----------------------------------------------------------------------------
// pdvm_post
// Applies sign, saturates, merges faults; holds the output register.
// ----------------------------------------------------------------------------
module pdvm_post
    import pdvm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ld,
    input  logic          i_vld,
    input  logic [QW-1:0] i_quo [LANES],
    input  t_flags        i_flg [LANES],
    output logic          o_vld,
    output logic [QW-1:0] o_res [LANES],
    output logic          o_fault
);

    logic          r_vld;
    logic [QW-1:0] r_res [LANES];
    logic          r_fault;

    logic [QW-1:0] n_res [LANES];
    logic          n_fault;

    always_comb begin
        n_fault = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            if (i_flg[l].dz) begin
                n_fault  = 1'b1;
                n_res[l] = !i_flg[l].nz ? '0 : (i_flg[l].neg ? SAT_MIN : SAT_MAX);
            end else if (i_flg[l].neg) begin
                if (i_flg[l].big || (i_quo[l] > SAT_MIN)) begin
                    n_fault  = 1'b1;
                    n_res[l] = SAT_MIN;
                end else begin
                    n_res[l] = QW'(-i_quo[l]);
                end
            end else begin
                if (i_flg[l].big || (i_quo[l] > SAT_MAX)) begin
                    n_fault  = 1'b1;
                    n_res[l] = SAT_MAX;
                end else begin
                    n_res[l] = i_quo[l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ld) begin
            r_vld <= i_vld;
        end
        if (i_ld) begin
            r_res   <= n_res;
            r_fault <= n_fault;
        end
    end

    assign o_vld   = r_vld;
    assign o_res   = r_res;
    assign o_fault = r_fault;

endmodule
